FILE: design/tdsw_pkg.sv
package tdsw_pkg;

    // Sizing
    localparam int MAX_RESIDUALS  = 1024;
    localparam int MAX_ITERATIONS = 64;
    localparam int STORE_AW       = $clog2(MAX_RESIDUALS);
    localparam int COUNT_W        = $clog2(MAX_RESIDUALS + 1);
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int ENTRY_W        = 25;

    // Fixed-point constants
    localparam logic [47:0] LAMBDA_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] LAMBDA_TOL = 48'd4294967;
    localparam logic [31:0] SCALE_MIN  = 32'd66;
    localparam logic [31:0] SCALE_RST  = 32'd65536;
    localparam logic [7:0]  DOF_RST    = 8'd5;
    localparam logic [15:0] SIGMA_RST  = 16'd1280;

    // Request / result codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_WEIGHT = 1'b1;
    localparam logic KIND_SCALE  = 1'b0;
    localparam logic KIND_WEIGHT = 1'b1;

    // Register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DOF   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 1'd1;

    typedef struct packed {
        logic              req_type;
        logic signed [23:0] residual;
        logic              finite;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] scale;
        logic [17:0] weight;
        logic        converged;
        logic        empty_set;
    } out_item_t;

    typedef enum logic {
        ARITH_MUL,
        ARITH_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

endpackage

FILE: design/tdsw_arith.sv
module tdsw_arith (
    input  logic                clk,
    input  logic                rst_n,
    input  tdsw_pkg::arith_req_t req,
    input  logic [63:0]         opa,
    input  logic [63:0]         opb,
    input  logic [63:0]         opc,
    output logic                done,
    output logic [127:0]        result
);
    import tdsw_pkg::*;

    // Shared unit: shift-add multiply opa*opb, or restoring divide
    // (opa:opb)/opc with saturation to all ones on overflow.
    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIN
    } astate_t;

    astate_t      state_reg;
    arith_op_t    op_reg;
    logic [127:0] acc_reg;
    logic [127:0] mcand_reg;
    logic [63:0]  mplier_reg;
    logic [63:0]  rem_reg;
    logic [63:0]  lo_reg;
    logic [63:0]  q_reg;
    logic [63:0]  den_reg;
    logic [5:0]   cnt_reg;

    logic [63:0]  rem_sh;
    logic         step_ge;

    always_comb
    begin
        rem_sh  = {rem_reg[62:0], lo_reg[63]};
        step_ge = rem_reg[63] || (rem_sh >= den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            op_reg     <= ARITH_MUL;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            rem_reg    <= '0;
            lo_reg     <= '0;
            q_reg      <= '0;
            den_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (req.start)
        begin
            op_reg <= req.op;
            if (req.op == ARITH_MUL)
            begin
                acc_reg    <= '0;
                mcand_reg  <= {64'd0, opa};
                mplier_reg <= opb;
                state_reg  <= A_MUL;
            end
            else if ((opc == 64'd0) || (opa >= opc))
            begin
                q_reg     <= '1;
                state_reg <= A_FIN;
            end
            else
            begin
                rem_reg   <= opa;
                lo_reg    <= opb;
                den_reg   <= opc;
                q_reg     <= '0;
                cnt_reg   <= '0;
                state_reg <= A_DIV;
            end
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    state_reg <= A_IDLE;
                end
                A_MUL:
                begin
                    if (mplier_reg == 64'd0)
                    begin
                        state_reg <= A_FIN;
                    end
                    else
                    begin
                        if (mplier_reg[0])
                        begin
                            acc_reg <= acc_reg + mcand_reg;
                        end
                        mcand_reg  <= {mcand_reg[126:0], 1'b0};
                        mplier_reg <= {1'b0, mplier_reg[63:1]};
                    end
                end
                A_DIV:
                begin
                    rem_reg <= step_ge ? (rem_sh - den_reg) : rem_sh;
                    lo_reg  <= {lo_reg[62:0], 1'b0};
                    q_reg   <= {q_reg[62:0], step_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                    begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign done   = (state_reg == A_FIN);
    assign result = (op_reg == ARITH_MUL) ? acc_reg : {64'd0, q_reg};

endmodule

FILE: design/tdsw_store.sv
module tdsw_store (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [tdsw_pkg::STORE_AW-1:0]     wr_addr,
    input  logic [tdsw_pkg::ENTRY_W-1:0]      wr_data,
    input  logic                              rd_en,
    input  logic [tdsw_pkg::STORE_AW-1:0]     rd_addr,
    output logic [tdsw_pkg::ENTRY_W-1:0]      rd_data
);
    import tdsw_pkg::*;

    // Entry layout: {finite, residual}
    logic [ENTRY_W-1:0] mem [MAX_RESIDUALS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: design/t_distribution_scale_weight_unit.sv
// Student-t robust scale estimator and weight unit. Load transfers
// (req_type 0) write one Q15.8 residual and its finite flag into a
// 1024-entry store and give no result; loads past a full
// store are dropped. The load marked last runs the estimation: lambda starts
// at 1/initial_sigma^2, each pass walks the stored set and sets lambda to
// count / sum(r^2(dof+1)/(dof + r^2*lambda)), stopping when lambda moves by
// at most 0.001 or after 64 passes, then scale = max(1/sqrt(lambda), 0.001)
// in Q16.16 is stored and reported with a converged flag. An empty or
// all-non-finite set reports empty_set and keeps the scale. A weight query
// (req_type 1) returns (dof+1)/(dof+(r/scale)^2) in Q2.16, 0 if not finite.
// All quotients and the lambda and square-root products go through one
// shared unit: a shift-add multiplier (one multiplier bit per cycle, stops
// at the top set bit) and a 64-step restoring divider. A weight query uses
// two divides. An estimation uses one divide per pass plus, per finite
// residual and pass, one multiply and one divide, and a final reciprocal
// square root of 32 bit steps. in_stall is high for the whole of that work;
// one finished result may wait in the output register while the next
// transfer is taken.
module t_distribution_scale_weight_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  tdsw_pkg::in_item_t                in_data,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output tdsw_pkg::out_item_t               out_data,
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tdsw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [15:0]                       cfg_data
);
    import tdsw_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_INIT_DIV,
        S_INIT_WAIT,
        S_RD,
        S_GOT,
        S_SQ,
        S_MWAIT,
        S_TWAIT,
        S_QDIV,
        S_QWAIT,
        S_RS_BIT,
        S_RS_SQW,
        S_RS_LW,
        S_W_SQ,
        S_W_UDIV,
        S_W_UW,
        S_W_WW,
        S_EMIT
    } state_t;

    state_t             state_reg;

    // registers
    logic [7:0]         dof_reg;
    logic [15:0]        sigma_reg;
    logic [31:0]        scale_reg;

    // set bookkeeping
    logic [COUNT_W-1:0] load_cnt_reg;
    logic [COUNT_W-1:0] fin_cnt_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic [ITER_W-1:0]  iter_reg;

    // datapath
    logic [47:0]        lam_reg;
    logic [47:0]        lamb_reg;
    logic [63:0]        sum_reg;
    logic [47:0]        r2_reg;
    logic [56:0]        num_reg;
    logic [31:0]        ss_reg;
    logic [63:0]        sc2_reg;
    logic [31:0]        s_reg;
    logic [4:0]         bit_reg;
    logic [23:0]        res_in_reg;

    // result holding
    logic               res_kind_reg;
    logic [17:0]        res_weight_reg;
    logic               res_conv_reg;
    logic               res_empty_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    // shared unit
    arith_req_t         areq;
    logic [63:0]        opa;
    logic [63:0]        opb;
    logic [63:0]        opc;
    logic               adone;
    logic [127:0]       ares;

    // store
    logic               st_wr;
    logic               st_rd;
    logic [ENTRY_W-1:0] st_rdata;

    logic               in_xfer;
    logic               store_room;
    logic [7:0]         dof_e;
    logic [8:0]         dof_p1;
    logic [15:0]        sig_e;
    logic [23:0]        mag_in;
    logic [23:0]        mag_st;
    logic [47:0]        lam_q;
    logic [47:0]        lam_diff;
    logic [48:0]        u_clamp;
    logic [31:0]        t_val;
    logic               rs_ok;
    logic [31:0]        s_new;

    function automatic logic [23:0] mag_of(input logic [23:0] v);
        return v[23] ? (~v + 24'd1) : v;
    endfunction

    assign in_xfer    = in_valid && !in_stall;
    assign in_stall   = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign store_room = (load_cnt_reg < COUNT_W'(MAX_RESIDUALS));

    assign dof_e  = (dof_reg == 8'd0) ? 8'd1 : dof_reg;
    assign dof_p1 = {1'b0, dof_e} + 9'd1;
    assign sig_e  = (sigma_reg == 16'd0) ? 16'd1 : sigma_reg;
    assign mag_in = mag_of(res_in_reg);
    assign mag_st = mag_of(st_rdata[23:0]);

    // new lambda from a quotient, saturated to Q16.32
    assign lam_q    = (ares[63:48] != 16'd0) ? LAMBDA_MAX : ares[47:0];
    assign lam_diff = (lam_q > lamb_reg) ? (lam_q - lamb_reg) : (lamb_reg - lam_q);

    // weight: r^2/scale^2 capped at 1.0 * 2^32 in Q.16
    assign u_clamp = (ares[63:0] > 64'h0001_0000_0000_0000)
                     ? 49'h1_0000_0000_0000 : ares[48:0];

    // reciprocal square root bit trial: keep bit if t^2 * lambda <= 2^64
    assign t_val = s_reg | (32'd1 << bit_reg);
    assign rs_ok = (ares[127:65] == 63'd0) && (!ares[64] || (ares[63:0] == 64'd0));
    assign s_new = rs_ok ? t_val : s_reg;

    // shared unit requests
    always_comb
    begin
        areq = '{start: 1'b0, op: ARITH_MUL};
        opa  = '0;
        opb  = '0;
        opc  = '0;
        unique case (state_reg)
            S_INIT_DIV:
            begin
                areq = '{start: 1'b1, op: ARITH_DIV};
                opb  = 64'd1 << 48;
                opc  = 64'(ss_reg);
            end
            S_SQ:
            begin
                areq = '{start: 1'b1, op: ARITH_MUL};
                opa  = 64'(r2_reg);
                opb  = 64'(lamb_reg);
            end
            S_MWAIT:
            begin
                // term = r^2 (dof+1) 2^16 / (dof 2^16 + r^2 lambda)
                areq = '{start: adone, op: ARITH_DIV};
                opa  = 64'(num_reg >> 48);
                opb  = {num_reg[47:0], 16'd0};
                opc  = (64'(dof_e) << 16) + ares[95:32];
            end
            S_QDIV:
            begin
                areq = '{start: 1'b1, op: ARITH_DIV};
                opa  = 64'(fin_cnt_reg) >> 16;
                opb  = 64'(fin_cnt_reg) << 48;
                opc  = sum_reg;
            end
            S_RS_BIT:
            begin
                areq = '{start: 1'b1, op: ARITH_MUL};
                opa  = 64'(t_val);
                opb  = 64'(t_val);
            end
            S_RS_SQW:
            begin
                areq = '{start: adone, op: ARITH_MUL};
                opa  = ares[63:0];
                opb  = 64'(lam_reg);
            end
            S_W_UDIV:
            begin
                areq = '{start: 1'b1, op: ARITH_DIV};
                opa  = 64'(r2_reg[47:32]);
                opb  = {r2_reg[31:0], 32'd0};
                opc  = sc2_reg;
            end
            S_W_UW:
            begin
                areq = '{start: adone, op: ARITH_DIV};
                opb  = 64'(dof_p1) << 32;
                opc  = (64'(dof_e) << 16) + 64'(u_clamp);
            end
            default:
            begin
                areq = '{start: 1'b0, op: ARITH_MUL};
            end
        endcase
    end

    assign st_wr = in_xfer && (in_data.req_type == REQ_LOAD) && store_room;
    assign st_rd = (state_reg == S_RD) && (idx_reg != load_cnt_reg);

    tdsw_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (areq),
        .opa    (opa),
        .opb    (opb),
        .opc    (opc),
        .done   (adone),
        .result (ares)
    );

    tdsw_store u_store (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (load_cnt_reg[STORE_AW-1:0]),
        .wr_data ({in_data.finite, in_data.residual}),
        .rd_en   (st_rd),
        .rd_addr (idx_reg[STORE_AW-1:0]),
        .rd_data (st_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            dof_reg        <= DOF_RST;
            sigma_reg      <= SIGMA_RST;
            scale_reg      <= SCALE_RST;
            load_cnt_reg   <= '0;
            fin_cnt_reg    <= '0;
            idx_reg        <= '0;
            iter_reg       <= '0;
            lam_reg        <= '0;
            lamb_reg       <= '0;
            sum_reg        <= '0;
            r2_reg         <= '0;
            num_reg        <= '0;
            ss_reg         <= '0;
            sc2_reg        <= '0;
            s_reg          <= '0;
            bit_reg        <= '0;
            res_in_reg     <= '0;
            res_kind_reg   <= KIND_SCALE;
            res_weight_reg <= '0;
            res_conv_reg   <= 1'b0;
            res_empty_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            // S_EMIT owns out_valid_reg while it loads a new result
            if (out_valid_reg && !out_stall && (state_reg != S_EMIT))
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DOF:   dof_reg   <= cfg_data[7:0];
                    REG_SIGMA: sigma_reg <= cfg_data;
                    default:   dof_reg   <= dof_reg;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        res_in_reg <= in_data.residual;
                        if (in_data.req_type == REQ_LOAD)
                        begin
                            if (store_room)
                            begin
                                load_cnt_reg <= load_cnt_reg + COUNT_W'(1);
                                if (in_data.finite)
                                begin
                                    fin_cnt_reg <= fin_cnt_reg + COUNT_W'(1);
                                end
                            end
                            if (in_data.last)
                            begin
                                state_reg <= S_CHECK;
                            end
                        end
                        else
                        begin
                            res_kind_reg  <= KIND_WEIGHT;
                            res_conv_reg  <= 1'b0;
                            res_empty_reg <= 1'b0;
                            if (in_data.finite)
                            begin
                                state_reg <= S_W_SQ;
                            end
                            else
                            begin
                                res_weight_reg <= '0;
                                state_reg      <= S_EMIT;
                            end
                        end
                    end
                end
                S_CHECK:
                begin
                    res_kind_reg   <= KIND_SCALE;
                    res_weight_reg <= '0;
                    ss_reg         <= 32'(sig_e) * 32'(sig_e);
                    if (fin_cnt_reg == '0)
                    begin
                        res_conv_reg  <= 1'b0;
                        res_empty_reg <= 1'b1;
                        load_cnt_reg  <= '0;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        res_empty_reg <= 1'b0;
                        state_reg     <= S_INIT_DIV;
                    end
                end
                S_INIT_DIV:
                begin
                    state_reg <= S_INIT_WAIT;
                end
                S_INIT_WAIT:
                begin
                    if (adone)
                    begin
                        lam_reg   <= lam_q;
                        lamb_reg  <= lam_q;
                        sum_reg   <= '0;
                        idx_reg   <= '0;
                        iter_reg  <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    state_reg <= (idx_reg == load_cnt_reg) ? S_QDIV : S_GOT;
                end
                S_GOT:
                begin
                    if (st_rdata[24])
                    begin
                        r2_reg    <= 48'(mag_st) * 48'(mag_st);
                        state_reg <= S_SQ;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + COUNT_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_SQ:
                begin
                    num_reg   <= 57'(r2_reg) * 57'(dof_p1);
                    state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (adone)
                    begin
                        state_reg <= S_TWAIT;
                    end
                end
                S_TWAIT:
                begin
                    if (adone)
                    begin
                        sum_reg   <= sum_reg + ares[63:0];
                        idx_reg   <= idx_reg + COUNT_W'(1);
                        state_reg <= S_RD;
                    end
                end
                S_QDIV:
                begin
                    state_reg <= S_QWAIT;
                end
                S_QWAIT:
                begin
                    if (adone)
                    begin
                        lam_reg <= lam_q;
                        if ((lam_diff <= LAMBDA_TOL)
                            || (iter_reg == ITER_W'(MAX_ITERATIONS - 1)))
                        begin
                            res_conv_reg <= (lam_diff <= LAMBDA_TOL);
                            s_reg        <= '0;
                            bit_reg      <= 5'd31;
                            state_reg    <= S_RS_BIT;
                        end
                        else
                        begin
                            iter_reg  <= iter_reg + ITER_W'(1);
                            lamb_reg  <= lam_q;
                            sum_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RS_BIT:
                begin
                    state_reg <= S_RS_SQW;
                end
                S_RS_SQW:
                begin
                    if (adone)
                    begin
                        state_reg <= S_RS_LW;
                    end
                end
                S_RS_LW:
                begin
                    if (adone)
                    begin
                        s_reg <= s_new;
                        if (bit_reg == 5'd0)
                        begin
                            scale_reg    <= (s_new < SCALE_MIN) ? SCALE_MIN : s_new;
                            load_cnt_reg <= '0;
                            fin_cnt_reg  <= '0;
                            state_reg    <= S_EMIT;
                        end
                        else
                        begin
                            bit_reg   <= bit_reg - 5'd1;
                            state_reg <= S_RS_BIT;
                        end
                    end
                end
                S_W_SQ:
                begin
                    r2_reg    <= 48'(mag_in) * 48'(mag_in);
                    sc2_reg   <= 64'(scale_reg) * 64'(scale_reg);
                    state_reg <= S_W_UDIV;
                end
                S_W_UDIV:
                begin
                    state_reg <= S_W_UW;
                end
                S_W_UW:
                begin
                    if (adone)
                    begin
                        state_reg <= S_W_WW;
                    end
                end
                S_W_WW:
                begin
                    if (adone)
                    begin
                        res_weight_reg <= ares[17:0];
                        state_reg      <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg            <= 1'b1;
                        out_data_reg.result_kind <= res_kind_reg;
                        out_data_reg.scale       <= scale_reg;
                        out_data_reg.weight      <= res_weight_reg;
                        out_data_reg.converged   <= res_conv_reg;
                        out_data_reg.empty_set   <= res_empty_reg;
                        if (res_kind_reg == KIND_SCALE)
                        begin
                            fin_cnt_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: design/tdsw_checker.sv
module tdsw_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input tdsw_pkg::in_item_t   in_data,
    input logic                 out_valid,
    input logic                 out_stall,
    input tdsw_pkg::out_item_t  out_data
);
    import tdsw_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // weight results carry no estimation flags and a weight of at most 2.0
    a_weight_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind == KIND_WEIGHT)
            |-> !out_data.converged && !out_data.empty_set && (out_data.weight <= 18'd131072))
        else $error("bad weight result");

    // an estimate never falls below the scale floor
    a_scale_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind == KIND_SCALE) && !out_data.empty_set
            |-> out_data.scale >= SCALE_MIN)
        else $error("scale below floor");

    a_empty_conv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.empty_set |-> !out_data.converged)
        else $error("empty set reported converged");

    // a query occupies the unit for at least the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_data.req_type == REQ_WEIGHT) |=> in_stall)
        else $error("query did not occupy the unit");

endmodule

bind t_distribution_scale_weight_unit tdsw_checker u_tdsw_checker (.*);

FILE: tb/tb_top.sv
module tb_top;
    import tdsw_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_data;
    logic out_valid;
    logic out_stall;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    t_distribution_scale_weight_unit DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Predictor state: shadow registers and shadow of the residual store
    logic [7:0]  p_dof;
    logic [15:0] p_sigma;
    logic [24:0] p_store [MAX_RESIDUALS];
    int          p_count;
    logic [31:0] p_scale;

    out_item_t expected_q[$];
    int fail_count;
    int n_loads;
    int n_queries;
    int n_scale_results;
    int n_weight_results;
    int n_converged;
    int n_empty;
    bit quiet_mode;    // when set, no idling on either side

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #80000000;
        $display("timeout: %0d results still expected", expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    // floor((hi:lo)/d), saturating on overflow or zero divisor
    function automatic logic [63:0] wide_div(logic [63:0] hi, logic [63:0] lo,
                                             logic [63:0] d);
        logic [127:0] num;
        logic [127:0] q;
        if (d == 0 || hi >= d)
            return '1;
        num = {hi, lo};
        q = num / {64'd0, d};
        return q[63:0];
    endfunction

    function automatic logic [63:0] res_square(logic [23:0] r);
        logic [23:0] m;
        m = r[23] ? (~r + 24'd1) : r;
        return {40'd0, m} * {40'd0, m};
    endfunction

    // floor(2^32/sqrt(L)), bitwise search
    function automatic logic [31:0] inv_root(logic [47:0] l);
        logic [31:0] s;
        logic [31:0] t;
        logic [127:0] p;
        s = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = s | (32'd1 << b);
            p = ({96'd0, t} * {96'd0, t}) * {80'd0, l};
            if (p <= (128'd1 << 64))
                s = t;
        end
        return s;
    endfunction

    function automatic out_item_t predict_scale();
        out_item_t o;
        logic [63:0] d;
        logic [63:0] cnt;
        logic [63:0] ss;
        logic [63:0] lam;
        logic [63:0] lam_prev;
        logic [63:0] sum;
        logic [63:0] r2;
        logic [127:0] prod;
        logic [63:0] u;
        logic [127:0] num;
        logic [63:0] q;
        logic [63:0] diff;
        logic [31:0] s;
        bit conv;
        d = (p_dof == 0) ? 64'd1 : {56'd0, p_dof};
        cnt = 0;
        conv = 0;
        for (int i = 0; i < p_count; i++)
            if (p_store[i][24])
                cnt++;
        o = '0;
        o.result_kind = KIND_SCALE;
        if (cnt == 0)
        begin
            o.scale = p_scale;
            o.empty_set = 1'b1;
            p_count = 0;
            return o;
        end
        ss = (p_sigma == 0) ? 64'd1 : {48'd0, p_sigma};
        ss = ss * ss;
        lam = (64'd1 << 48) / ss;
        if (lam > LAMBDA_MAX)
            lam = LAMBDA_MAX;
        for (int it = 0; it < MAX_ITERATIONS; it++)
        begin
            lam_prev = lam;
            sum = 0;
            for (int i = 0; i < p_count; i++)
            begin
                if (!p_store[i][24])
                    continue;
                r2 = res_square(p_store[i][23:0]);
                prod = {64'd0, r2} * {64'd0, lam_prev};
                u = prod[95:32];
                num = {64'd0, r2} * {64'd0, d + 64'd1};
                sum += wide_div(num[111:48], {num[47:0], 16'd0}, (d << 16) + u);
            end
            q = wide_div(cnt >> 16, cnt << 48, sum);
            lam = (q > LAMBDA_MAX) ? LAMBDA_MAX : q;
            diff = (lam > lam_prev) ? lam - lam_prev : lam_prev - lam;
            if (diff <= LAMBDA_TOL)
            begin
                conv = 1;
                break;
            end
        end
        s = inv_root(lam[47:0]);
        if (s < SCALE_MIN)
            s = SCALE_MIN;
        p_scale = s;
        o.scale = s;
        o.converged = conv;
        p_count = 0;
        return o;
    endfunction

    function automatic out_item_t predict_weight(in_item_t it);
        out_item_t o;
        logic [63:0] d;
        logic [63:0] r2;
        logic [63:0] sc;
        logic [63:0] u;
        logic [63:0] w;
        o = '0;
        o.result_kind = KIND_WEIGHT;
        o.scale = p_scale;
        if (it.finite)
        begin
            d = (p_dof == 0) ? 64'd1 : {56'd0, p_dof};
            r2 = res_square(it.residual);
            sc = {32'd0, p_scale};
            u = wide_div(r2 >> 32, r2 << 32, sc * sc);
            if (u > (64'd1 << 48))
                u = 64'd1 << 48;
            w = ((d + 64'd1) << 32) / ((d << 16) + u);
            o.weight = w[17:0];
        end
        return o;
    endfunction

    // Append one prediction to the tail of the expected queue
    function automatic void add_expected(out_item_t o);
        expected_q = {expected_q, o};
    endfunction

    // Update the predictor for one accepted item
    function automatic void predict_item(in_item_t it);
        if (it.req_type == REQ_LOAD)
        begin
            n_loads++;
            if (p_count < MAX_RESIDUALS)
            begin
                p_store[p_count] = {it.finite, it.residual};
                p_count++;
            end
            if (it.last)
                add_expected(predict_scale());
        end
        else
        begin
            n_queries++;
            add_expected(predict_weight(it));
        end
    endfunction

    function automatic bit idle_now();
        return !quiet_mode && ($urandom_range(99) < 7);
    endfunction

    // Send one item; valid only drops when an idle cycle is chosen
    task automatic send_item(in_item_t it);
        while (idle_now())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_item(it);
    endtask

    task automatic go_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drain();
        go_idle();
        while (expected_q.size() != 0)
            @(posedge clk);
        // allow an in-flight load with no result to settle
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_DOF)
            p_dof = val[7:0];
        else
            p_sigma = val;
        @(posedge clk);
    endtask

    function automatic in_item_t mk_item(logic rt, logic [23:0] r, logic f, logic l);
        in_item_t it;
        it.req_type = rt;
        it.residual = r;
        it.finite = f;
        it.last = l;
        return it;
    endfunction

    // Residual with a spread of magnitudes, so small values dominate
    function automatic logic [23:0] rand_residual();
        int sh;
        logic [23:0] v;
        sh = $urandom_range(23);
        v = 24'($urandom());
        v = v >> sh;
        if ($urandom_range(1))
            v = ~v + 24'd1;
        return v;
    endfunction

    // Result checker: compare each transfer against the oldest prediction
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: %p", out_data);
                fail_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_data.result_kind != e.result_kind)
                begin
                    $error("result_kind exp %0d got %0d", e.result_kind,
                           out_data.result_kind);
                    fail_count++;
                end
                if (out_data.scale != e.scale)
                begin
                    $error("scale exp %0d got %0d", e.scale, out_data.scale);
                    fail_count++;
                end
                if (out_data.weight != e.weight)
                begin
                    $error("weight exp %0d got %0d", e.weight, out_data.weight);
                    fail_count++;
                end
                if (out_data.converged != e.converged)
                begin
                    $error("converged exp %0d got %0d", e.converged,
                           out_data.converged);
                    fail_count++;
                end
                if (out_data.empty_set != e.empty_set)
                begin
                    $error("empty_set exp %0d got %0d", e.empty_set,
                           out_data.empty_set);
                    fail_count++;
                end
                if (e.result_kind == KIND_SCALE)
                begin
                    n_scale_results++;
                    n_converged += e.converged;
                    n_empty += e.empty_set;
                end
                else
                    n_weight_results++;
            end
        end
    end

    // Receiver stall, driven at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= idle_now();
    end

    // Extremes of the residual field, every request type, non-finite flags
    task automatic test_directed();
        send_item(mk_item(REQ_WEIGHT, 24'h000000, 1'b1, 1'b0));
        send_item(mk_item(REQ_WEIGHT, 24'h7FFFFF, 1'b1, 1'b0));
        send_item(mk_item(REQ_WEIGHT, 24'h800000, 1'b1, 1'b0));
        send_item(mk_item(REQ_WEIGHT, 24'hFFFFFF, 1'b0, 1'b1));
        send_item(mk_item(REQ_LOAD, 24'h000100, 1'b1, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'hFFFF00, 1'b1, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h7FFFFF, 1'b0, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h000280, 1'b1, 1'b1));
        send_item(mk_item(REQ_WEIGHT, 24'h000180, 1'b1, 1'b0));
        // empty set: scale kept
        send_item(mk_item(REQ_LOAD, 24'h000000, 1'b0, 1'b1));
        // all non-finite set
        send_item(mk_item(REQ_LOAD, 24'h123456, 1'b0, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h800000, 1'b0, 1'b1));
        // all zero residuals: lambda saturates, scale drops to 256 (1/256 in Q16.16)
        send_item(mk_item(REQ_LOAD, 24'h000000, 1'b1, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h000000, 1'b1, 1'b1));
        send_item(mk_item(REQ_WEIGHT, 24'h000001, 1'b1, 1'b0));
        // extreme residuals in one set
        send_item(mk_item(REQ_LOAD, 24'h7FFFFF, 1'b1, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h800000, 1'b1, 1'b0));
        send_item(mk_item(REQ_LOAD, 24'h000001, 1'b1, 1'b1));
        send_item(mk_item(REQ_WEIGHT, 24'h555555, 1'b1, 1'b0));
        send_item(mk_item(REQ_WEIGHT, 24'hAAAAAA, 1'b1, 1'b0));
        wait_drain();
    endtask

    // Store overflow: 1024 fills it, the rest are dropped, last still runs
    task automatic test_store_full();
        quiet_mode = 1;
        for (int i = 0; i < MAX_RESIDUALS + 3; i++)
            send_item(mk_item(REQ_LOAD, (i < 4) ? rand_residual() : 24'd0,
                              (i < 4), (i == MAX_RESIDUALS + 2)));
        quiet_mode = 0;
        wait_drain();
    endtask

    // Random mix: mostly well-formed small sets followed by queries
    task automatic test_random(int n_items);
        int sent;
        int set_len;
        sent = 0;
        while (sent < n_items)
        begin
            set_len = $urandom_range(7, 1);
            for (int i = 0; i < set_len; i++)
            begin
                send_item(mk_item(REQ_LOAD, rand_residual(),
                                  ($urandom_range(9) != 0), (i == set_len - 1)));
                sent++;
            end
            repeat ($urandom_range(3))
            begin
                send_item(mk_item(REQ_WEIGHT, rand_residual(),
                                  ($urandom_range(9) != 0), 1'($urandom_range(1))));
                sent++;
            end
        end
        wait_drain();
    endtask

    // Register sweep: extremes and random settings of both registers
    task automatic test_config_sweep();
        logic [15:0] dofs [4];
        logic [15:0] sigmas [4];
        dofs = '{16'd1, 16'd255, 16'd0, 16'd5};
        sigmas = '{16'd1, 16'hFFFF, 16'd0, 16'd1280};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_DOF, dofs[k]);
            write_reg(REG_SIGMA, sigmas[k]);
            test_random(8);
        end
        write_reg(REG_DOF, 16'($urandom_range(255, 1)));
        write_reg(REG_SIGMA, 16'($urandom_range(65535, 1)));
        test_random(8);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fail_count = 0;
        quiet_mode = 0;
        p_dof = DOF_RST;
        p_sigma = SIGMA_RST;
        p_count = 0;
        p_scale = SCALE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_store_full();
        // long burst with no idling on either side
        quiet_mode = 1;
        test_random(24);
        quiet_mode = 0;
        test_random(24);

        if (expected_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_q.size());
            fail_count++;
        end
        $display("Covered %0d loads, %0d weight queries; %0d scale results", n_loads,
                 n_queries, n_scale_results);
        $display("(%0d converged, %0d empty), %0d weight results", n_converged,
                 n_empty, n_weight_results);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
